// ===== hw/rtl/yuv_pkg.sv =====
// ----------------------------------------------------------------------------
// YUV 4:2:2 to I420 converter package
// Shared constants, register codes and item types of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yuv_pkg;

  // Frame geometry limits.
  localparam int unsigned MaxPairs = 2048;
  localparam int unsigned MaxRows  = 4096;

  // Derived counter widths.
  localparam int unsigned ColW  = $clog2(MaxPairs);
  localparam int unsigned PairW = $clog2(MaxPairs + 1);
  localparam int unsigned RowW  = $clog2(MaxRows + 1);

  // Fixed register and field widths.
  localparam int unsigned SrcPairsW  = 12;
  localparam int unsigned OutRowsW   = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned LumaIdxW   = 23;
  localparam int unsigned ChromaIdxW = 22;

  // Widths wide enough to compare raw register values against the limits.
  localparam int unsigned PairCmpW = (PairW > SrcPairsW) ? PairW : SrcPairsW;
  localparam int unsigned RowCmpW  = (RowW > OutRowsW) ? RowW : OutRowsW;

  // Register reset values.
  localparam logic [SrcPairsW-1:0] SrcPairsRst = 12'd320;
  localparam logic [SrcPairsW-1:0] OutPairsRst = 12'd320;
  localparam logic [OutRowsW-1:0]  OutRowsRst  = 13'd480;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgByteOrder   = 2'd0,
    CfgSourcePairs = 2'd1,
    CfgOutPairs    = 2'd2,
    CfgOutRows     = 2'd3
  } cfg_reg_e;

  // Byte order of the packed macropixel.
  typedef enum logic {
    OrderYuyv = 1'b0,
    OrderUyvy = 1'b1
  } order_e;

  // One packed macropixel as received.
  typedef struct packed {
    logic       frame_start;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
  } in_item_t;

  // One planar result item.
  typedef struct packed {
    logic [LumaIdxW-1:0]   luma_index;
    logic [7:0]            luma_left;
    logic [7:0]            luma_right;
    logic                  chroma_valid;
    logic [ChromaIdxW-1:0] chroma_index;
    logic [7:0]            chroma_u;
    logic [7:0]            chroma_v;
    logic                  frame_last;
  } out_item_t;

  // Effective (saturated) configuration.
  typedef struct packed {
    order_e           byte_order;
    logic [PairW-1:0] src_pairs;
    logic [PairW-1:0] out_pairs;
    logic [RowW-1:0]  out_rows;
  } cfg_t;

  // Position decision for the item in the work stage.
  typedef struct packed {
    logic                  emit;
    logic                  even;
    logic                  last;
    logic [LumaIdxW-1:0]   luma_index;
    logic [ChromaIdxW-1:0] chroma_index;
  } pos_t;

endpackage

// ===== hw/rtl/yuv_if.sv =====
// ----------------------------------------------------------------------------
// YUV converter channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Input macropixel channel.
interface yuv_in_if;
  logic             valid;
  logic             ready;
  yuv_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result item channel.
interface yuv_out_if;
  logic               valid;
  logic               ready;
  yuv_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Register write channel.
interface yuv_cfg_if;
  logic                             valid;
  logic                             ready;
  yuv_pkg::cfg_reg_e                index;
  logic [yuv_pkg::CfgDataW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/yuv_cfg.sv =====
// ----------------------------------------------------------------------------
// YUV converter configuration registers
// Holds the written registers and saturates them into their legal ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  yuv_cfg_if.sink         cfg_i,
  output yuv_pkg::cfg_t   cfg_o
);

  yuv_pkg::order_e                  order_q;
  logic [yuv_pkg::SrcPairsW-1:0]    src_q;
  logic [yuv_pkg::SrcPairsW-1:0]    outp_q;
  logic [yuv_pkg::OutRowsW-1:0]     rows_q;

  logic [yuv_pkg::PairCmpW-1:0]     src_ext;
  logic [yuv_pkg::PairCmpW-1:0]     outp_ext;
  logic [yuv_pkg::PairCmpW-1:0]     src_sat;
  logic [yuv_pkg::PairCmpW-1:0]     outp_sat;
  logic [yuv_pkg::RowCmpW-1:0]      rows_ext;
  logic [yuv_pkg::RowCmpW-1:0]      rows_sat;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= yuv_pkg::OrderYuyv;
      src_q   <= yuv_pkg::SrcPairsRst;
      outp_q  <= yuv_pkg::OutPairsRst;
      rows_q  <= yuv_pkg::OutRowsRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        yuv_pkg::CfgByteOrder:   order_q <= yuv_pkg::order_e'(cfg_i.data[0]);
        yuv_pkg::CfgSourcePairs: src_q   <= cfg_i.data[yuv_pkg::SrcPairsW-1:0];
        yuv_pkg::CfgOutPairs:    outp_q  <= cfg_i.data[yuv_pkg::SrcPairsW-1:0];
        yuv_pkg::CfgOutRows:     rows_q  <= cfg_i.data[yuv_pkg::OutRowsW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the row lengths; the kept length never exceeds the source length.
  always_comb begin
    src_ext  = yuv_pkg::PairCmpW'(src_q);
    outp_ext = yuv_pkg::PairCmpW'(outp_q);
    if (src_ext == '0) begin
      src_sat = yuv_pkg::PairCmpW'(1);
    end else if (src_ext > yuv_pkg::PairCmpW'(yuv_pkg::MaxPairs)) begin
      src_sat = yuv_pkg::PairCmpW'(yuv_pkg::MaxPairs);
    end else begin
      src_sat = src_ext;
    end
    if (outp_ext == '0) begin
      outp_sat = yuv_pkg::PairCmpW'(1);
    end else if (outp_ext > src_sat) begin
      outp_sat = src_sat;
    end else begin
      outp_sat = outp_ext;
    end
  end

  // Saturate the kept row count.
  always_comb begin
    rows_ext = yuv_pkg::RowCmpW'(rows_q);
    if (rows_ext == '0) begin
      rows_sat = yuv_pkg::RowCmpW'(1);
    end else if (rows_ext > yuv_pkg::RowCmpW'(yuv_pkg::MaxRows)) begin
      rows_sat = yuv_pkg::RowCmpW'(yuv_pkg::MaxRows);
    end else begin
      rows_sat = rows_ext;
    end
  end

  assign cfg_o.byte_order = order_q;
  assign cfg_o.src_pairs  = src_sat[yuv_pkg::PairW-1:0];
  assign cfg_o.out_pairs  = outp_sat[yuv_pkg::PairW-1:0];
  assign cfg_o.out_rows   = rows_sat[yuv_pkg::RowW-1:0];

endmodule

// ===== hw/rtl/yuv_pos.sv =====
// ----------------------------------------------------------------------------
// YUV converter position tracker
// Column, row and plane position counters, with crop and frame-end decisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_pos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic          frame_start_i,
  input  yuv_pkg::cfg_t cfg_i,
  output yuv_pkg::pos_t pos_o
);

  // Compare widths with one spare bit for the incremented counters.
  localparam int unsigned CmpW  = yuv_pkg::PairW + 1;
  localparam int unsigned RCmpW = yuv_pkg::RowW + 1;

  logic [yuv_pkg::ColW-1:0]       col_q, col_c, col_d;
  logic [yuv_pkg::RowW-1:0]       row_q, row_c, row_d;
  logic [yuv_pkg::LumaIdxW-1:0]   luma_q, luma_c, luma_d;
  logic [yuv_pkg::ChromaIdxW-1:0] chroma_q, chroma_c, chroma_d;
  logic                           fin_q, fin_c, fin_d;

  logic [CmpW-1:0]                col_inc;
  logic [RCmpW-1:0]               row_inc;
  logic                           emit;
  logic                           even;
  logic                           wrap;

  // A frame start clears the position before the item is handled.
  always_comb begin
    if (frame_start_i) begin
      col_c    = '0;
      row_c    = '0;
      luma_c   = '0;
      chroma_c = '0;
      fin_c    = 1'b0;
    end else begin
      col_c    = col_q;
      row_c    = row_q;
      luma_c   = luma_q;
      chroma_c = chroma_q;
      fin_c    = fin_q;
    end
  end

  // Crop, parity and row-wrap decisions.
  assign col_inc = CmpW'(col_c) + CmpW'(1);
  assign row_inc = RCmpW'(row_c) + RCmpW'(1);
  assign even    = ~row_c[0];
  assign emit    = !fin_c && (CmpW'(col_c) < CmpW'(cfg_i.out_pairs));
  assign wrap    = col_inc >= CmpW'(cfg_i.src_pairs);

  // Next position; nothing moves while waiting for a frame start.
  always_comb begin
    col_d    = col_c;
    row_d    = row_c;
    luma_d   = luma_c;
    chroma_d = chroma_c;
    fin_d    = fin_c;
    if (!fin_c) begin
      if (emit) begin
        luma_d = luma_c + yuv_pkg::LumaIdxW'(1);
        if (even) begin
          chroma_d = chroma_c + yuv_pkg::ChromaIdxW'(1);
        end
      end
      if (wrap) begin
        col_d = '0;
        row_d = row_inc[yuv_pkg::RowW-1:0];
        if (row_inc >= RCmpW'(cfg_i.out_rows)) begin
          fin_d = 1'b1;
        end
      end else begin
        col_d = col_inc[yuv_pkg::ColW-1:0];
      end
    end
  end

  // Position state advances once per item leaving the work stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      luma_q   <= '0;
      chroma_q <= '0;
      fin_q    <= 1'b1;
    end else if (fire_i) begin
      col_q    <= col_d;
      row_q    <= row_d;
      luma_q   <= luma_d;
      chroma_q <= chroma_d;
      fin_q    <= fin_d;
    end
  end

  assign pos_o.emit         = emit;
  assign pos_o.even         = even;
  assign pos_o.last         = (col_inc == CmpW'(cfg_i.out_pairs)) &&
                              (row_inc >= RCmpW'(cfg_i.out_rows));
  assign pos_o.luma_index   = luma_c;
  assign pos_o.chroma_index = chroma_c;

  // An emitted item moves the luma position on by exactly one.
  a_luma_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && emit |=> luma_q == $past(luma_c) + yuv_pkg::LumaIdxW'(1))
    else $error("luma position did not advance by one");

  // A dropped item outside a frame start leaves the luma position alone.
  a_luma_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !emit && !frame_start_i |=> $stable(luma_q))
    else $error("luma position moved on a dropped item");

endmodule

// ===== hw/rtl/packed_yuv422_to_planar_i420.sv =====
// ----------------------------------------------------------------------------
// Packed YUV 4:2:2 to planar I420 converter
// Crops packed macropixels to the output frame and splits them into luma and
// even-row chroma samples with their plane indexes.
// ----------------------------------------------------------------------------
// Path: an accepted item moves from the input register to the result register,
// where its result is valid; an untaken result can hold it in the input register.
// Throughput: one item per cycle; the input stalls only while a result is
// held in the result register and not taken, and the item in the work stage also emits.
// Reset: registers take their defaults, counters clear and the block drops
// items until one carries a frame start.
`timescale 1ns / 1ps

module packed_yuv422_to_planar_i420 (
  input  logic       clk_i,
  input  logic       rst_ni,
  yuv_in_if.sink     in_i,
  yuv_out_if.source  out_o,
  yuv_cfg_if.sink    cfg_i
);

  yuv_pkg::cfg_t      cfg;
  yuv_pkg::pos_t      pos;

  logic               s1_valid_q;
  yuv_pkg::in_item_t  s1_q;
  logic               out_valid_q;
  yuv_pkg::out_item_t out_q;
  yuv_pkg::out_item_t res_d;

  logic               in_ready;
  logic               in_fire;
  logic               out_free;
  logic               s1_fire;
  logic [7:0]         y0, y1, u, v;

  // Configuration registers.
  yuv_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Position tracking for the item in the work stage.
  yuv_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_fire),
    .frame_start_i (s1_q.frame_start),
    .cfg_i         (cfg),
    .pos_o         (pos)
  );

  // Handshake: the work stage empties unless it must wait for the result slot.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && (!pos.emit || out_free);
  assign in_ready   = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
  end

  // Byte lanes by configured order.
  always_comb begin
    case (cfg.byte_order)
      yuv_pkg::OrderUyvy: begin
        u  = s1_q.first_byte;
        y0 = s1_q.second_byte;
        v  = s1_q.third_byte;
        y1 = s1_q.fourth_byte;
      end
      default: begin
        y0 = s1_q.first_byte;
        u  = s1_q.second_byte;
        y1 = s1_q.third_byte;
        v  = s1_q.fourth_byte;
      end
    endcase
  end

  // Result assembly; chroma fields are zero on odd rows.
  always_comb begin
    res_d.luma_index   = pos.luma_index;
    res_d.luma_left    = y0;
    res_d.luma_right   = y1;
    res_d.chroma_valid = pos.even;
    res_d.chroma_index = pos.even ? pos.chroma_index : '0;
    res_d.chroma_u     = pos.even ? u : 8'd0;
    res_d.chroma_v     = pos.even ? v : 8'd0;
    res_d.frame_last   = pos.last;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && pos.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && pos.emit) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // An empty work stage always takes a new item.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with an empty work stage");

  // An emitting item leaving the work stage shows up as a result.
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && pos.emit |=> out_valid_q)
    else $error("emitted item did not reach the result register");

  // Odd-row results carry no chroma.
  a_odd_row_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.chroma_valid |->
      out_q.chroma_index == '0 && out_q.chroma_u == 8'd0 && out_q.chroma_v == 8'd0)
    else $error("chroma fields set on an odd row");

endmodule
